### sv/etld_pkg.sv
// Shared widths, register codes, queue entry types and calendar helpers.
package etld_pkg;

	localparam int unsigned EPOCH_W    = 32;
	localparam int unsigned OFS_W      = 18;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned YEAR_W     = 12;
	localparam int unsigned MONTH_W    = 4;
	localparam int unsigned DAY_W      = 5;
	localparam int unsigned HOUR_W     = 5;
	localparam int unsigned MIN_W      = 6;
	localparam int unsigned SEC_W      = 6;

	// Biased local seconds: local + 4 days, never negative, below 2^33.
	localparam int unsigned BIAS_W   = 33;
	localparam int unsigned SOD_W    = 17;
	localparam int unsigned QUO_W    = 17;
	localparam int unsigned DAYS_W   = 18;
	localparam int unsigned YLEN_W   = 9;
	localparam int unsigned M100_W   = 7;
	localparam int unsigned M400_W   = 9;

	localparam logic [BIAS_W-1:0]        DAY_BIAS     = 33'd345600;
	localparam logic signed [DAYS_W-1:0] BIAS_DAYS    = 18'sd4;
	localparam logic [SOD_W-1:0]         SEC_PER_DAY  = 17'd86400;
	localparam logic [SOD_W-1:0]         SEC_PER_HOUR = 17'd3600;
	localparam logic [SOD_W-1:0]         SEC_PER_MIN  = 17'd60;

	localparam logic [YEAR_W-1:0] BASE_YEAR    = 12'd1970;
	localparam logic [M100_W-1:0] BASE_MOD100  = 7'd70;
	localparam logic [M400_W-1:0] BASE_MOD400  = 9'd370;
	localparam logic [M100_W-1:0] MOD100_LAST  = 7'd99;
	localparam logic [M400_W-1:0] MOD400_LAST  = 9'd399;
	localparam logic [YLEN_W-1:0] LEAP_YEAR_LEN = 9'd366;
	localparam logic [YLEN_W-1:0] YEAR_LEN      = 9'd365;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GMT_OFS   = 2'd0,
		REG_DST_OFS   = 2'd1,
		REG_MIN_EPOCH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BIAS_W-1:0]  local_b;
		logic [EPOCH_W-1:0] epoch;
		logic               epoch_valid;
	} etld_req_t;

	typedef struct packed {
		logic      push;
		etld_req_t data;
	} etld_q_wr_t;

	typedef struct packed {
		logic      avail;
		etld_req_t data;
	} etld_q_rd_t;

	// Gregorian leap rule from the year's low bits and its running residues.
	function automatic logic is_leap(input logic [1:0] y_lo, input logic [M100_W-1:0] m100,
			input logic [M400_W-1:0] m400);
		is_leap = ((y_lo == 2'd0) && (m100 != '0)) || (m400 == '0);
	endfunction

	function automatic logic [YLEN_W-1:0] year_days(input logic leap);
		year_days = leap ? LEAP_YEAR_LEN : YEAR_LEN;
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m, input logic leap);
		if (m == MONTH_FEB) begin
			month_days = leap ? 5'd29 : 5'd28;
		end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
			month_days = 5'd30;
		end else begin
			month_days = 5'd31;
		end
	endfunction

endpackage

### sv/etld_in_if.sv
// Request channel: epoch seconds with valid/ready.
interface etld_in_if import etld_pkg::*;;
	logic               valid;
	logic               ready;
	logic [EPOCH_W-1:0] epoch_sec;

	modport source (output valid, output epoch_sec, input ready);
	modport sink (input valid, input epoch_sec, output ready);
endinterface

### sv/etld_out_if.sv
// Result channel: local calendar date and time with valid/ready.
interface etld_out_if import etld_pkg::*;;
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  cal_year;
	logic [MONTH_W-1:0] cal_month;
	logic [DAY_W-1:0]   cal_day;
	logic [HOUR_W-1:0]  hour_of_day;
	logic [MIN_W-1:0]   minute_of_hour;
	logic [SEC_W-1:0]   second_of_minute;
	logic [EPOCH_W-1:0] epoch_echo;
	logic               epoch_valid;

	modport source (output valid, output cal_year, output cal_month, output cal_day,
		output hour_of_day, output minute_of_hour, output second_of_minute,
		output epoch_echo, output epoch_valid, input ready);
	modport sink (input valid, input cal_year, input cal_month, input cal_day,
		input hour_of_day, input minute_of_hour, input second_of_minute,
		input epoch_echo, input epoch_valid, output ready);
endinterface

### sv/etld_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
interface etld_cfg_if import etld_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/etld_front.sv
// Front end: config registers, offset sum and validity check per request.
module etld_front import etld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	etld_in_if.sink    in_ch,
	etld_cfg_if.sink   cfg,
	input  logic       q_full,
	output etld_q_wr_t q_wr
);

	logic signed [OFS_W-1:0] gmt_q;
	logic signed [OFS_W-1:0] dst_q;
	logic [EPOCH_W-1:0]      min_epoch_q;
	logic signed [BIAS_W:0]  local_s;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gmt_q       <= '0;
			dst_q       <= '0;
			min_epoch_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_GMT_OFS:   gmt_q       <= signed'(cfg.data[OFS_W-1:0]);
				REG_DST_OFS:   dst_q       <= signed'(cfg.data[OFS_W-1:0]);
				REG_MIN_EPOCH: min_epoch_q <= cfg.data[EPOCH_W-1:0];
				default: ;
			endcase
		end
	end

	// Bias by four days so the local count is never negative.
	assign local_s = signed'({{(BIAS_W+1-EPOCH_W){1'b0}}, in_ch.epoch_sec})
		+ (BIAS_W+1)'(gmt_q) + (BIAS_W+1)'(dst_q) + signed'({1'b0, DAY_BIAS});

	assign q_wr.push             = in_ch.valid && in_ch.ready;
	assign q_wr.data.local_b     = local_s[BIAS_W-1:0];
	assign q_wr.data.epoch       = in_ch.epoch_sec;
	assign q_wr.data.epoch_valid = (in_ch.epoch_sec >= min_epoch_q);

endmodule

### sv/etld_queue.sv
// Short request queue between front end and back end.
module etld_queue import etld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  etld_q_wr_t q_wr,
	output logic       full,
	input  logic       pop,
	output etld_q_rd_t q_rd
);

	etld_req_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_rd.avail = (cnt_q != '0);
	assign q_rd.data  = mem_q[rd_ptr_q];
	assign do_push    = q_wr.push && !full;
	assign do_pop     = pop && q_rd.avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/etld_back.sv
// Back end: day split, year and month walk, time-of-day split, result register.
module etld_back import etld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  etld_q_rd_t q_rd,
	output logic       pop,
	etld_out_if.source out_ch
);

	localparam int unsigned DIV_STEPS = 2;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [YEAR_W-1:0] YEAR_LO = 12'd1969;
	localparam logic [YEAR_W-1:0] YEAR_HI = 12'd2106;

	// 86400 = 675 * 2^7: drop the low seven bits, then divide by 675 with a
	// reciprocal that is exact for every 26-bit dividend.
	localparam int unsigned DIV_SHIFT   = 7;
	localparam int unsigned NUM_HI_W    = BIAS_W - DIV_SHIFT;
	localparam int unsigned RECIP_W     = 27;
	localparam int unsigned RECIP_SHIFT = 36;
	localparam int unsigned PROD_W      = NUM_HI_W + RECIP_W;
	localparam logic [NUM_HI_W-1:0] DAY_ODD   = NUM_HI_W'(SEC_PER_DAY >> DIV_SHIFT);
	localparam logic [RECIP_W-1:0]  DAY_RECIP = 27'd101806633;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_YEAR  = 5'b00100,
		ST_MONTH = 5'b01000,
		ST_DONE  = 5'b10000
	} back_state_t;

	typedef enum logic [3:0] {
		HMS_IDLE = 4'b0001,
		HMS_HOUR = 4'b0010,
		HMS_MIN  = 4'b0100,
		HMS_DONE = 4'b1000
	} hms_state_t;

	back_state_t              state_q;
	hms_state_t               hms_state_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;
	logic [BIAS_W-1:0]        num_q;
	logic [QUO_W-1:0]         quo_q;
	logic [EPOCH_W-1:0]       epoch_q;
	logic                     ev_q;
	logic signed [DAYS_W-1:0] days_q;
	logic [YEAR_W-1:0]        year_q;
	logic [M100_W-1:0]        m100_q;
	logic [M400_W-1:0]        m400_q;
	logic [MONTH_W-1:0]       month_q;
	logic [SOD_W-1:0]         sod_q;
	logic [HOUR_W-1:0]        hour_q;
	logic [MIN_W-1:0]         min_q;
	logic                     out_valid_q;

	logic [NUM_HI_W-1:0]      num_hi;
	logic [PROD_W-1:0]        prod;
	logic [QUO_W-1:0]         quo_nx;
	logic [NUM_HI_W-1:0]      rem_hi;
	logic [SOD_W-1:0]         sod_nx;
	logic                     leap_cur;
	logic [M100_W-1:0]        m100_prev;
	logic [M400_W-1:0]        m400_prev;
	logic                     leap_prev;
	logic signed [DAYS_W-1:0] ylen_cur;
	logic signed [DAYS_W-1:0] ylen_prev;
	logic signed [DAYS_W-1:0] mlen_cur;
	logic                     load_out;

	// Day number by reciprocal multiply into quo_q, then the remainder from the registered quotient.
	assign num_hi = num_q[BIAS_W-1:DIV_SHIFT];
	assign prod   = {{RECIP_W{1'b0}}, num_hi} * {{NUM_HI_W{1'b0}}, DAY_RECIP};
	assign quo_nx = prod[PROD_W-1:RECIP_SHIFT];
	assign rem_hi = num_hi - {{(NUM_HI_W-QUO_W){1'b0}}, quo_q} * DAY_ODD;
	assign sod_nx = {rem_hi[SOD_W-DIV_SHIFT-1:0], num_q[DIV_SHIFT-1:0]};

	assign leap_cur  = is_leap(year_q[1:0], m100_q, m400_q);
	assign m100_prev = (m100_q == '0) ? MOD100_LAST : m100_q - 1'b1;
	assign m400_prev = (m400_q == '0) ? MOD400_LAST : m400_q - 1'b1;
	assign leap_prev = is_leap(year_q[1:0] - 2'd1, m100_prev, m400_prev);
	assign ylen_cur  = signed'({{(DAYS_W-YLEN_W){1'b0}}, year_days(leap_cur)});
	assign ylen_prev = signed'({{(DAYS_W-YLEN_W){1'b0}}, year_days(leap_prev)});
	assign mlen_cur  = signed'({{(DAYS_W-DAY_W){1'b0}}, month_days(month_q, leap_cur)});

	assign pop      = (state_q == ST_IDLE) && q_rd.avail;
	assign load_out = (state_q == ST_DONE) && (hms_state_q == HMS_DONE)
		&& (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hms_state_q <= HMS_IDLE;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_rd.avail) begin
						state_q   <= ST_DIV;
						div_cnt_q <= '0;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q     <= ST_YEAR;
						hms_state_q <= HMS_HOUR;
					end
				end
				ST_YEAR: begin
					if (!(days_q >= ylen_cur) && !days_q[DAYS_W-1]) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (month_q == MONTH_DEC || days_q < mlen_cur) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q     <= ST_IDLE;
						hms_state_q <= HMS_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			unique case (hms_state_q)
				HMS_HOUR: if (sod_q < SEC_PER_HOUR) hms_state_q <= HMS_MIN;
				HMS_MIN:  if (sod_q < SEC_PER_MIN) hms_state_q <= HMS_DONE;
				HMS_IDLE, HMS_DONE: ;
				default: hms_state_q <= HMS_IDLE;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				num_q   <= q_rd.data.local_b;
				epoch_q <= q_rd.data.epoch;
				ev_q    <= q_rd.data.epoch_valid;
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					days_q <= signed'({1'b0, quo_q}) - BIAS_DAYS;
					year_q <= BASE_YEAR;
					m100_q <= BASE_MOD100;
					m400_q <= BASE_MOD400;
					sod_q  <= sod_nx;
					hour_q <= '0;
					min_q  <= '0;
				end else begin
					quo_q <= quo_nx;
				end
			end
			ST_YEAR: begin
				if (days_q >= ylen_cur) begin
					days_q <= days_q - ylen_cur;
					year_q <= year_q + 1'b1;
					m100_q <= (m100_q == MOD100_LAST) ? '0 : m100_q + 1'b1;
					m400_q <= (m400_q == MOD400_LAST) ? '0 : m400_q + 1'b1;
				end else if (days_q[DAYS_W-1]) begin
					days_q <= days_q + ylen_prev;
					year_q <= year_q - 1'b1;
					m100_q <= m100_prev;
					m400_q <= m400_prev;
				end else begin
					month_q <= MONTH_JAN;
				end
			end
			ST_MONTH: begin
				if (month_q != MONTH_DEC && days_q >= mlen_cur) begin
					days_q  <= days_q - mlen_cur;
					month_q <= month_q + 1'b1;
				end
			end
			ST_DONE: ;
			default: ;
		endcase

		// Time-of-day split runs alongside the year and month walk.
		unique case (hms_state_q)
			HMS_HOUR: begin
				if (sod_q >= SEC_PER_HOUR) begin
					sod_q  <= sod_q - SEC_PER_HOUR;
					hour_q <= hour_q + 1'b1;
				end
			end
			HMS_MIN: begin
				if (sod_q >= SEC_PER_MIN) begin
					sod_q <= sod_q - SEC_PER_MIN;
					min_q <= min_q + 1'b1;
				end
			end
			HMS_IDLE, HMS_DONE: ;
			default: ;
		endcase

		if (load_out) begin
			out_ch.cal_year         <= year_q;
			out_ch.cal_month        <= month_q;
			out_ch.cal_day          <= days_q[DAY_W-1:0] + 1'b1;
			out_ch.hour_of_day      <= hour_q;
			out_ch.minute_of_hour   <= min_q;
			out_ch.second_of_minute <= sod_q[SEC_W-1:0];
			out_ch.epoch_echo       <= epoch_q;
			out_ch.epoch_valid      <= ev_q;
		end
	end

	assign out_ch.valid = out_valid_q;

`ifndef SYNTHESIS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) |-> (rem_hi < DAY_ODD))
		else $error("day remainder out of range");
	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) |-> (year_q >= YEAR_LO && year_q <= YEAR_HI))
		else $error("year walk left the supported span");
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> (!days_q[DAYS_W-1] && month_q >= MONTH_JAN
		&& month_q <= MONTH_DEC))
		else $error("month walk with bad day or month");
	a_pop_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_DIV && div_cnt_q == '0))
		else $error("popped request did not start the day split");
	a_hms_done: assert property (@(posedge clk) disable iff (!arst_n)
		(hms_state_q == HMS_DONE) |-> (sod_q < SEC_PER_MIN && hour_q < 5'd24))
		else $error("time-of-day split incomplete");
`endif

endmodule

### sv/epoch_to_local_datetime_top.sv
// Top level of the epoch to local date and time converter.
//
// Converts a 32-bit Unix epoch second count to local Gregorian year, month,
// day, hour, minute and second after adding the signed zone and daylight
// offsets, echoes the epoch and flags whether it reaches the configured
// minimum. A request passes from acceptance to result through these steps:
// a start state, a split of the local count into days and second-of-day by
// a reciprocal multiply, a year walk year by year from 1970 (forward toward
// 2106, or back to 1969 for a local time before 1970) plus a step to end
// it, a month walk month by month (up to December) plus a step to end it,
// and the load of the result register. The hour/minute split starts with
// the year walk and counts down hour by hour, then minute by minute; the
// result waits for it whenever it outlasts the year and month walk, which
// happens for local dates in the first years after 1970. A result that
// waits to be taken adds its wait. The back end works on one request at a
// time and takes the next one from the queue in the cycle after it loads a
// result; the front end keeps accepting into a two-entry queue, and the
// result register lets the next request start while a result waits to be
// taken. Configuration writes are taken at any time (ready is always high)
// but must only be issued while no request is in flight; index 3 is ignored.
module epoch_to_local_datetime_top import etld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	etld_in_if.sink    in_ch,
	etld_out_if.source out_ch,
	etld_cfg_if.sink   cfg
);

	etld_q_wr_t q_wr;
	etld_q_rd_t q_rd;
	logic       q_full;
	logic       q_pop;

	// Accept requests, hold config, add offsets and check validity.
	etld_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	// Decouple the front end from the long-running back end.
	etld_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.q_rd   (q_rd)
	);

	// Walk days, years and months; register the result.
	etld_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

endmodule

### test/tb_epoch_to_local_datetime_top.sv
// Testbench for the epoch to local date and time converter, checked against a local predictor.
`timescale 1ns / 100ps

module tb_epoch_to_local_datetime_top;
	import etld_pkg::*;

	// Stimulus shape and run limits.
	localparam int NUM_SETTINGS      = 9;
	localparam int ITEMS_PER_SETTING = 200;
	localparam int HOLD_CYCLES       = 1500;  // long receiver hold-off, fills the block
	localparam int SETTLE_CYCLES     = 250;   // above the worst request latency
	localparam int WATCHDOG_LIMIT    = 20000; // cycles with no request or result moving at all
	localparam int MAX_REPORTS       = 50;

	// Index 3 is not a register; the block drops writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [YEAR_W-1:0]  cal_year;
		logic [MONTH_W-1:0] cal_month;
		logic [DAY_W-1:0]   cal_day;
		logic [HOUR_W-1:0]  hour_of_day;
		logic [MIN_W-1:0]   minute_of_hour;
		logic [SEC_W-1:0]   second_of_minute;
		logic [EPOCH_W-1:0] epoch_echo;
		logic               epoch_valid;
	} calendar_t;

	// Holds its own copy of the registers, predicts each accepted request and
	// checks results in order against the oldest prediction.
	class calendar_scoreboard;
		logic signed [OFS_W-1:0] gmt_ofs;
		logic signed [OFS_W-1:0] dst_ofs;
		logic [EPOCH_W-1:0]      min_epoch;
		calendar_t               expected_q[$];
		int unsigned             checked;
		int unsigned             mismatches;
		int unsigned             pre_1970;
		int                      low_year;
		int                      high_year;

		function new();
			gmt_ofs    = '0;
			dst_ofs    = '0;
			min_epoch  = '0;
			checked    = 0;
			mismatches = 0;
			pre_1970   = 0;
			low_year   = 4095;
			high_year  = 0;
		endfunction

		static function bit leap_year(int y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GMT_OFS:   gmt_ofs = data[OFS_W-1:0];
				REG_DST_OFS:   dst_ofs = data[OFS_W-1:0];
				REG_MIN_EPOCH: min_epoch = data;
				default: ;
			endcase
		endfunction

		function calendar_t to_local_calendar(logic [EPOCH_W-1:0] epoch);
			calendar_t r;
			longint    loc;
			longint    days;
			longint    sod;
			longint    dim;
			int        year;
			int        month;
			loc  = longint'(epoch) + longint'(gmt_ofs) + longint'(dst_ofs);
			days = loc / 86400;
			sod  = loc % 86400;
			// floor the day number for local times before 1970
			if (sod < 0) begin
				sod  += 86400;
				days -= 1;
			end
			year = 1970;
			while (days >= (leap_year(year) ? 366 : 365)) begin
				days -= leap_year(year) ? 366 : 365;
				year++;
			end
			while (days < 0) begin
				year--;
				days += leap_year(year) ? 366 : 365;
			end
			month = 1;
			while (month < 12) begin
				if (month == 2)
					dim = leap_year(year) ? 29 : 28;
				else if (month == 4 || month == 6 || month == 9 || month == 11)
					dim = 30;
				else
					dim = 31;
				if (days < dim)
					break;
				days -= dim;
				month++;
			end
			r.cal_year         = YEAR_W'(year);
			r.cal_month        = MONTH_W'(month);
			r.cal_day          = DAY_W'(days + 1);
			r.hour_of_day      = HOUR_W'(sod / 3600);
			r.minute_of_hour   = MIN_W'((sod % 3600) / 60);
			r.second_of_minute = SEC_W'(sod % 60);
			r.epoch_echo       = epoch;
			r.epoch_valid      = (epoch >= min_epoch);
			return r;
		endfunction

		function void note_request(logic [EPOCH_W-1:0] epoch);
			expected_q.push_back(to_local_calendar(epoch));
		endfunction

		function int pending_count();
			return expected_q.size();
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(calendar_t got);
			calendar_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with no request pending, expected none actual epoch %0d",
						$time, got.epoch_echo);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			compare_field("cal_year", want.cal_year, got.cal_year);
			compare_field("cal_month", want.cal_month, got.cal_month);
			compare_field("cal_day", want.cal_day, got.cal_day);
			compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
			compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
			compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
			compare_field("epoch_echo", want.epoch_echo, got.epoch_echo);
			compare_field("epoch_valid", want.epoch_valid, got.epoch_valid);
			if (int'(want.cal_year) < low_year)
				low_year = int'(want.cal_year);
			if (int'(want.cal_year) > high_year)
				high_year = int'(want.cal_year);
			if (want.cal_year < 12'd1970)
				pre_1970++;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	etld_in_if  in_ch ();
	etld_out_if out_ch ();
	etld_cfg_if cfg_ch ();

	epoch_to_local_datetime_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	calendar_scoreboard sb;
	bit                 hold_request;  // ask the receiver for one long hold-off
	bit                 no_idle;       // both sides run without random gaps
	int                 idle_cycles;

	// Hand-picked epochs: both ends of the range, day and year edges, leap days
	// (2000 is a leap year, 2100 is not) and the signed 32-bit rollover.
	logic [EPOCH_W-1:0] directed_epochs [15] = '{
		32'd0, 32'd1, 32'd59, 32'd86399, 32'd86400,
		32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
		32'd4107542399, 32'd4107542400, 32'd2147483647, 32'd2147483648,
		32'hFFFF_FFFE, 32'hFFFF_FFFF
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, a calm stretch on request, and one long hold-off
	// counted here so the sender keeps pushing while the block backs up.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ch.ready <= 1'b0;
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= no_idle || ($urandom_range(99) >= 8);
			end
		end
	end

	// Monitors: register writes, accepted requests and accepted results all
	// feed the scoreboard at the clock edge where their handshake completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_register(cfg_ch.index, cfg_ch.data);
			if (in_ch.valid && in_ch.ready)
				sb.note_request(in_ch.epoch_sec);
			if (out_ch.valid && out_ch.ready)
				sb.check_result('{out_ch.cal_year, out_ch.cal_month, out_ch.cal_day,
					out_ch.hour_of_day, out_ch.minute_of_hour, out_ch.second_of_minute,
					out_ch.epoch_echo, out_ch.epoch_valid});
		end
	end

	// Watchdog: stop the run if no request or result moves for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, sb.pending_count());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offer one request, with an occasional random gap ahead of it, and hold it until taken.
	// Valid stays high on return so the next request can follow back to back.
	task automatic send_request(logic [EPOCH_W-1:0] epoch);
		if (!no_idle && $urandom_range(99) < 8) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.epoch_sec <= epoch;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Drop valid and wait until every predicted result has come back, then
	// let the given number of extra cycles pass.
	task automatic drain_results(int extra);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Random requests: mostly full-range epochs, plus clusters near both ends
	// of the range (so offsets push local time across 1970 and to the top of the range), near the
	// validity threshold and near the start of a random year.
	task automatic run_random_requests(int count, bit pause_midway);
		logic [EPOCH_W-1:0] e;
		longint             acc;
		int                 y;
		int                 kind;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				drain_results(0);
			kind = $urandom_range(99);
			if (kind < 50) begin
				e = $urandom();
			end else if (kind < 65) begin
				e = $urandom_range(0, 400000);
			end else if (kind < 80) begin
				e = 32'hFFFF_FFFF - $urandom_range(0, 400000);
			end else if (kind < 90) begin
				e = sb.min_epoch + $urandom_range(0, 8) - 4;
			end else begin
				y   = $urandom_range(1971, 2106);
				acc = 0;
				for (int k = 1970; k < y; k++)
					acc += calendar_scoreboard::leap_year(k) ? 366 : 365;
				e = EPOCH_W'(acc * 86400 + $urandom_range(0, 200000) - 100000);
			end
			send_request(e);
		end
	endtask

	initial begin
		logic signed [OFS_W-1:0] gmt;
		logic signed [OFS_W-1:0] dst;
		logic [EPOCH_W-1:0]      min_ep;
		logic [31:0]             rnd;
		int                      settings;

		sb               = new();
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.epoch_sec  = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		hold_request     = 1'b0;
		no_idle          = 1'b0;
		idle_cycles      = 0;
		settings         = 1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: zero offsets, every epoch counts as valid.
		foreach (directed_epochs[i])
			send_request(directed_epochs[i]);
		drain_results(SETTLE_CYCLES);

		for (int ph = 1; ph < NUM_SETTINGS; ph++) begin
			case (ph)
				1: begin
					// most negative 18-bit offsets: epoch 0 lands in late December 1969
					gmt    = 18'sh20000;
					dst    = 18'sh20000;
					min_ep = 32'hFFFF_FFFF;
				end
				2: begin
					// most positive offsets: the top epoch reaches into 2106
					gmt    = 18'sh1FFFF;
					dst    = 18'sh1FFFF;
					min_ep = 32'd0;
				end
				3: begin
					gmt    = -18'sd86400;
					dst    = 18'sd86400;
					min_ep = $urandom();
				end
				4: begin
					gmt    = 18'sd19800;
					dst    = 18'sd3600;
					min_ep = $urandom();
				end
				5: begin
					gmt    = -18'sd18000;
					dst    = 18'sd0;
					min_ep = 32'h8000_0000;
				end
				default: begin
					rnd    = $urandom();
					gmt    = rnd[OFS_W-1:0];
					rnd    = $urandom();
					dst    = rnd[OFS_W-1:0];
					min_ep = $urandom();
				end
			endcase

			// Block is idle here; load all registers, with junk in the unused
			// upper data bits of the offsets, plus a write to the spare index.
			rnd = $urandom();
			write_register(REG_GMT_OFS, {rnd[CFG_DATA_W-1:OFS_W], gmt});
			rnd = $urandom();
			write_register(REG_DST_OFS, {rnd[CFG_DATA_W-1:OFS_W], dst});
			write_register(REG_MIN_EPOCH, min_ep);
			write_register(REG_SPARE, $urandom());
			cfg_ch.valid <= 1'b0;
			settings++;

			// At the extreme settings hit both range ends and the threshold edge.
			if (ph <= 2) begin
				send_request(32'd0);
				send_request(32'hFFFF_FFFF);
				send_request(min_ep);
				send_request(min_ep - 32'd1);
			end

			if (ph == 2)
				hold_request = 1'b1;
			no_idle = (ph == 4);
			run_random_requests(ITEMS_PER_SETTING, ph == 3);
			drain_results(SETTLE_CYCLES);
		end

		if (sb.pending_count() != 0)
			$display("%0t: %0d predicted results never arrived", $time, sb.pending_count());
		$display("Run covered %0d conversions over %0d register settings, local years %0d to %0d",
			sb.checked, settings, sb.low_year, sb.high_year);
		$display("%0d conversions fell before 1970; one long output hold-off, one input drain",
			sb.pre_1970);
		if (sb.mismatches == 0 && sb.pending_count() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
